// ----- rtl/rimsa_pkg.sv -----
package rimsa_pkg;

	localparam int ACTION_W    = 3;
	localparam int ROOM_W      = 6;
	localparam int VALUE_W     = 32;
	localparam int KIND_W      = 2;
	localparam int ANSWER_W    = 38;
	localparam int ROOMS_REG_W = 7;

	localparam logic [ROOMS_REG_W-1:0] ROOMS_RESET = 7'd64;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE = 3'd0,
		ACT_JOIN  = 3'd1,
		ACT_LEAVE = 3'd2,
		ACT_PLAY  = 3'd3,
		ACT_OCC   = 3'd4
	} action_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_INV = 2'd0,
		KIND_RUN = 2'd1,
		KIND_OCC = 2'd2
	} kind_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic               vacant;
		logic [VALUE_W-1:0] value;
	} room_entry_t;

	localparam int ENTRY_W = $bits(room_entry_t);

endpackage

// ----- rtl/rimsa_cfg_if.sv -----
interface rimsa_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [rimsa_pkg::ROOMS_REG_W-1:0]   rooms_in_use;

	modport source (output valid, output rooms_in_use, input ready);
	modport sink (input valid, input rooms_in_use, output ready);
endinterface

// ----- rtl/rimsa_req_if.sv -----
interface rimsa_req_if;
	logic                                valid;
	logic                                ready;
	logic [rimsa_pkg::ACTION_W-1:0]      action;
	logic [rimsa_pkg::ROOM_W-1:0]        room;
	logic signed [rimsa_pkg::VALUE_W-1:0] value;
	logic                                last;

	modport source (output valid, output action, output room, output value, output last,
		input ready);
	modport sink (input valid, input action, input room, input value, input last,
		output ready);
endinterface

// ----- rtl/rimsa_rsp_if.sv -----
interface rimsa_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic [rimsa_pkg::KIND_W-1:0]          kind;
	logic signed [rimsa_pkg::ANSWER_W-1:0] answer;

	modport source (output valid, output kind, output answer, input ready);
	modport sink (input valid, input kind, input answer, output ready);
endinterface

// ----- rtl/rimsa_ram.sv -----
module rimsa_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/rimsa_alu.sv -----
module rimsa_alu #(
	parameter int W = 39
) (
	input  rimsa_pkg::alu_op_t op,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic signed [W:0]   y
);

	always_comb begin
		unique case (op)
			rimsa_pkg::ALU_SUB: y = (W+1)'(a) - (W+1)'(b);
			default:            y = (W+1)'(a) + (W+1)'(b);
		endcase
	end

endmodule

// ----- rtl/room_inversion_and_max_subarray.sv -----
// Room table with inversion count and maximum run sum. Each of ROOMS rooms holds a signed
// 32-bit value and a vacancy mark in one single-port-read memory; each walk reads that
// memory one room per read under a small sequencer, and one shared adder/subtractor does the
// value comparisons and run sums. The block takes one request at a time (req.ready is high
// only when idle); a finished answer sits in an output register, so the next request is taken
// while it waits. After reset the block clears every room of the table before it takes the
// first request; the rooms_in_use register may be written at any idle time, and its effective
// size n is that register clamped into 1..ROOMS. A write marked last then runs the inversion
// walk, which reads each pair of rooms below n once through the one memory read port. A write
// or leave to a room at or beyond n leaves the table unchanged; actions 5 to 7 are dropped
// without an answer.
module room_inversion_and_max_subarray #(
	parameter int ROOMS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	rimsa_cfg_if.sink      cfg,
	rimsa_req_if.sink      req,
	rimsa_rsp_if.source    rsp
);

	localparam int IDX_W = $clog2(ROOMS);
	localparam int CNT_W = $clog2(ROOMS + 1);
	localparam int SUM_W = rimsa_pkg::VALUE_W + 1 + IDX_W;
	localparam int INV_W = 2 * CNT_W;

	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_WRITE,
		S_LEAVE,
		S_INV,
		S_JOIN,
		S_RUN,
		S_OCC,
		S_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [rimsa_pkg::ROOMS_REG_W-1:0] rooms_q;
	logic [CNT_W-1:0]                  size_n;
	logic [IDX_W-1:0]                  last_idx;

	// read stream: rd_q is the address the memory samples at each edge,
	// the _s1 tags travel with the data that comes back in the next cycle
	logic             iss_q;
	logic [IDX_W-1:0] rd_q;
	logic [IDX_W-1:0] pi_q;
	logic             issue_en;
	logic             vld_s1;
	logic [IDX_W-1:0] dix_s1;
	logic             outer_s1;

	// latched request fields
	logic [rimsa_pkg::ROOM_W-1:0]         room_q;
	logic signed [rimsa_pkg::VALUE_W-1:0] value_q;
	logic                                 last_q;
	logic                                 room_in;

	// walk accumulators
	logic signed [rimsa_pkg::VALUE_W-1:0] vi_q;
	logic                                 vi_occ_q;
	logic [INV_W-1:0]                     inv_q;
	logic [CNT_W-1:0]                     occ_q;
	logic signed [SUM_W-1:0]              cur_q;
	logic signed [SUM_W-1:0]              best_q;
	logic                                 phase_q;
	logic                                 pend_q;

	// result staging and output register
	rimsa_pkg::kind_t                      res_kind_q;
	logic signed [rimsa_pkg::ANSWER_W-1:0] res_ans_q;
	logic                                  out_vld_q;
	rimsa_pkg::kind_t                      out_kind_q;
	logic signed [rimsa_pkg::ANSWER_W-1:0] out_ans_q;

	// memory ports
	logic                              mem_we;
	logic [IDX_W-1:0]                  mem_waddr;
	rimsa_pkg::room_entry_t            mem_wdata;
	logic [rimsa_pkg::ENTRY_W-1:0]     mem_rdata;
	rimsa_pkg::room_entry_t            entry;

	// shared arithmetic unit
	rimsa_pkg::alu_op_t      alu_op;
	logic signed [SUM_W-1:0] alu_a;
	logic signed [SUM_W-1:0] alu_b;
	logic signed [SUM_W:0]   alu_y;
	logic                    alu_neg;
	logic                    walk_done;

	assign entry   = rimsa_pkg::room_entry_t'(mem_rdata);
	assign alu_neg = alu_y[SUM_W];

	// clamp the register into 1..ROOMS
	always_comb begin
		if (rooms_q == '0) begin
			size_n = CNT_W'(1);
		end else if (32'(rooms_q) > ROOMS) begin
			size_n = CNT_W'(ROOMS);
		end else begin
			size_n = CNT_W'(rooms_q);
		end
	end

	assign last_idx  = IDX_W'(size_n - CNT_W'(1));
	assign room_in   = 32'(req.room) < 32'(size_n);
	assign issue_en  = !((state_q == S_RUN) && phase_q);
	assign walk_done = !iss_q && !vld_s1;

	assign cfg.ready  = 1'b1;
	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = out_vld_q;
	assign rsp.kind   = out_kind_q;
	assign rsp.answer = out_ans_q;

	// Operand select for the shared unit. Inversion: v[j] - v[i] < 0 means v[i] > v[j].
	// Play, data cycle: max(cur, 0) + v. Play, other cycle: best - cur < 0 means cur wins.
	always_comb begin
		alu_op = rimsa_pkg::ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		unique case (state_q)
			S_INV: begin
				alu_op = rimsa_pkg::ALU_SUB;
				alu_a  = SUM_W'($signed(entry.value));
				alu_b  = SUM_W'(vi_q);
			end
			S_RUN: begin
				if (phase_q) begin
					alu_op = rimsa_pkg::ALU_ADD;
					alu_a  = (!cur_q[SUM_W-1] && (cur_q != '0)) ? cur_q : '0;
					alu_b  = SUM_W'($signed(entry.value));
				end else begin
					alu_op = rimsa_pkg::ALU_SUB;
					alu_a  = best_q;
					alu_b  = cur_q;
				end
			end
			default: begin
				alu_op = rimsa_pkg::ALU_ADD;
			end
		endcase
	end

	// Memory write port: clear sweep, leave, write-back of a stored value, join fill.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = dix_s1;
		mem_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = rd_q;
			end
			S_LEAVE: begin
				mem_we           = 1'b1;
				mem_waddr        = IDX_W'(room_q);
				mem_wdata.vacant = 1'b1;
			end
			S_WRITE: begin
				mem_we           = vld_s1;
				mem_wdata.vacant = entry.vacant;
				mem_wdata.value  = value_q;
			end
			S_JOIN: begin
				mem_we           = vld_s1 && entry.vacant;
				mem_wdata.vacant = 1'b0;
				mem_wdata.value  = value_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			rooms_q    <= rimsa_pkg::ROOMS_RESET;
			iss_q      <= 1'b0;
			rd_q       <= '0;
			pi_q       <= '0;
			vld_s1     <= 1'b0;
			dix_s1     <= '0;
			outer_s1   <= 1'b0;
			phase_q    <= 1'b0;
			pend_q     <= 1'b0;
			out_vld_q  <= 1'b0;
			out_kind_q <= rimsa_pkg::KIND_INV;
			res_kind_q <= rimsa_pkg::KIND_INV;
		end else begin
			if (cfg.valid) begin
				rooms_q <= cfg.rooms_in_use;
			end

			// drop the answer once the consumer takes it
			if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			// tag what the memory samples at this edge
			vld_s1   <= iss_q && issue_en;
			dix_s1   <= rd_q;
			outer_s1 <= (rd_q == pi_q);

			// advance the read address
			if (iss_q && issue_en) begin
				unique case (state_q)
					S_INV: begin
						// outer room i, then rooms i+1..n-1, then on to i+1
						if (rd_q == last_idx) begin
							if (pi_q == last_idx) begin
								iss_q <= 1'b0;
							end else begin
								pi_q <= pi_q + IDX_W'(1);
								rd_q <= pi_q + IDX_W'(1);
							end
						end else begin
							rd_q <= rd_q + IDX_W'(1);
						end
					end
					S_JOIN: begin
						if (rd_q == '0) begin
							iss_q <= 1'b0;
						end else begin
							rd_q <= rd_q - IDX_W'(1);
						end
					end
					S_OCC, S_RUN: begin
						if (rd_q == last_idx) begin
							iss_q <= 1'b0;
						end else begin
							rd_q <= rd_q + IDX_W'(1);
						end
					end
					default: begin
						iss_q <= 1'b0;
					end
				endcase
			end

			unique case (state_q)
				S_CLEAR: begin
					rd_q <= rd_q + IDX_W'(1);
					if (rd_q == IDX_W'(ROOMS - 1)) begin
						state_q <= S_IDLE;
					end
				end

				S_IDLE: begin
					if (req.valid) begin
						room_q  <= req.room;
						value_q <= req.value;
						last_q  <= req.last;
						unique case (rimsa_pkg::action_t'(req.action))
							rimsa_pkg::ACT_WRITE: begin
								if (room_in) begin
									rd_q    <= IDX_W'(req.room);
									iss_q   <= 1'b1;
									state_q <= S_WRITE;
								end else if (req.last) begin
									rd_q    <= '0;
									pi_q    <= '0;
									iss_q   <= 1'b1;
									inv_q   <= '0;
									state_q <= S_INV;
								end
							end
							rimsa_pkg::ACT_JOIN: begin
								rd_q    <= last_idx;
								iss_q   <= 1'b1;
								state_q <= S_JOIN;
							end
							rimsa_pkg::ACT_LEAVE: begin
								if (room_in) begin
									state_q <= S_LEAVE;
								end
							end
							rimsa_pkg::ACT_PLAY: begin
								rd_q    <= '0;
								iss_q   <= 1'b1;
								phase_q <= 1'b0;
								pend_q  <= 1'b0;
								cur_q   <= '0;
								best_q  <= SUM_MIN;
								state_q <= S_RUN;
							end
							rimsa_pkg::ACT_OCC: begin
								rd_q    <= '0;
								iss_q   <= 1'b1;
								occ_q   <= '0;
								state_q <= S_OCC;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end

				S_LEAVE: begin
					state_q <= S_IDLE;
				end

				S_WRITE: begin
					// the write-back keeps the room's vacancy mark
					if (vld_s1) begin
						if (last_q) begin
							rd_q    <= '0;
							pi_q    <= '0;
							iss_q   <= 1'b1;
							inv_q   <= '0;
							state_q <= S_INV;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end

				S_INV: begin
					if (vld_s1) begin
						if (outer_s1) begin
							vi_q     <= $signed(entry.value);
							vi_occ_q <= !entry.vacant;
						end else if (vi_occ_q && !entry.vacant && alu_neg) begin
							inv_q <= inv_q + INV_W'(1);
						end
					end
					if (walk_done) begin
						res_kind_q <= rimsa_pkg::KIND_INV;
						res_ans_q  <= rimsa_pkg::ANSWER_W'(inv_q);
						state_q    <= S_FIN;
					end
				end

				S_JOIN: begin
					// stop at the first vacant room from the top; the write port fills it
					if (vld_s1 && entry.vacant) begin
						iss_q   <= 1'b0;
						state_q <= S_IDLE;
					end else if (walk_done) begin
						state_q <= S_IDLE;
					end
				end

				S_RUN: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (vld_s1) begin
							cur_q  <= SUM_W'(alu_y);
							pend_q <= 1'b1;
						end
					end else if (pend_q) begin
						if (alu_neg) begin
							best_q <= cur_q;
						end
						pend_q <= 1'b0;
					end
					if (walk_done && !pend_q) begin
						res_kind_q <= rimsa_pkg::KIND_RUN;
						res_ans_q  <= rimsa_pkg::ANSWER_W'(best_q);
						state_q    <= S_FIN;
					end
				end

				S_OCC: begin
					if (vld_s1 && !entry.vacant) begin
						occ_q <= occ_q + CNT_W'(1);
					end
					if (walk_done) begin
						res_kind_q <= rimsa_pkg::KIND_OCC;
						res_ans_q  <= rimsa_pkg::ANSWER_W'(occ_q);
						state_q    <= S_FIN;
					end
				end

				S_FIN: begin
					// hold until the output register is free
					if (!out_vld_q || rsp.ready) begin
						out_vld_q  <= 1'b1;
						out_kind_q <= res_kind_q;
						out_ans_q  <= res_ans_q;
						state_q    <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	rimsa_ram #(
		.WIDTH (rimsa_pkg::ENTRY_W),
		.DEPTH (ROOMS)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_q),
		.rdata (mem_rdata)
	);

	rimsa_alu #(
		.W (SUM_W)
	) u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

endmodule
